// File: rtl/rstab_pkg.sv
package rstab_pkg;

  localparam int DEF_ENTRIES = 64;

  localparam int MODE_W = 3;
  localparam int ID_W   = 32;
  localparam int VAL_W  = 31;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 6;

  // one table row: valid mark, id, value
  localparam int ROW_W = 1 + ID_W + VAL_W;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_ID  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_VAL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

endpackage

// File: rtl/record_slot_table.sv
// Record slot table: ENTRIES slots, each with a valid mark, a 32-bit id and a
// 31-bit value, kept in one single-port-write, single-port-read memory.
// Input channel (in_valid/in_ready) carries one request: mode, key_id,
// data_value. Result channel (out_valid/out_ready) returns exactly one result
// per request: status, slot_index, entry_id, entry_value.
// Modes: clear all, insert into the lowest empty slot, find by id, find by
// value, delete by id. Unknown modes answer not found.
// Timing: one memory row is examined per cycle by the id or value compare,
// pipelined behind the registered memory read. Insert stops at the first
// empty slot and find at the first match; a miss, a full table and a delete
// scan every row. One request is worked at a time; in_ready is high only
// when idle.
// The result sits in an output register, so a new request may be accepted
// while the receiver stalls; that request finishes its scan and then waits
// in the response state until the output register frees up.
// Reset: rst_n (synchronous, active low) zeroes the id counter and starts a
// clearing pass that writes every row empty, one row per cycle. in_ready
// stays low until that pass is done.
module record_slot_table #(
  parameter int ENTRIES = rstab_pkg::DEF_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rstab_pkg::MODE_W-1:0] in_mode,
  input  logic [rstab_pkg::ID_W-1:0]   in_key_id,
  input  logic [rstab_pkg::VAL_W-1:0]  in_data_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rstab_pkg::ST_W-1:0]   out_status,
  output logic [rstab_pkg::SLOT_W-1:0] out_slot_index,
  output logic [rstab_pkg::ID_W-1:0]   out_entry_id,
  output logic [rstab_pkg::VAL_W-1:0]  out_entry_value
);
  import rstab_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);

  // row storage
  logic [ROW_W-1:0] mem_r [ENTRIES];
  logic [ROW_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  // sequencer
  state_t           state_r, state_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [ID_W-1:0]  cnt_r, cnt_nxt;

  // latched request
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;

  // pending result
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;

  // fields of the row that came back from the read issued last cycle
  logic             row_vld;
  logic [ID_W-1:0]  row_id;
  logic [VAL_W-1:0] row_val;
  logic [ID_W-1:0]  cnt_inc;

  assign row_vld = rd_data_r[ROW_W-1];
  assign row_id  = rd_data_r[ROW_W-2 -: ID_W];
  assign row_val = rd_data_r[VAL_W-1:0];
  assign cnt_inc = cnt_r + 32'd1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    cnt_nxt        = cnt_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_id_nxt     = res_id_r;
    res_val_nxt    = res_val_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_id_nxt     = out_id_r;
    out_val_nxt    = out_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_waddr      = issue_r[AW-1:0];
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = issue_r[AW-1:0];
    in_ready       = 1'b0;

    case (state_r)
      S_INIT, S_CLEAR: begin
        // sweep every row empty
        mem_we    = 1'b1;
        mem_waddr = issue_r[AW-1:0];
        mem_wdata = '0;
        issue_nxt = issue_r + 1'b1;
        if (issue_r == CNT_LAST) begin
          state_nxt = (state_r == S_CLEAR) ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt       = in_mode;
          key_nxt        = in_key_id;
          val_nxt        = in_data_value;
          issue_nxt      = '0;
          pend_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_id_nxt     = '0;
          res_val_nxt    = '0;
          if (in_mode == MODE_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (in_mode == MODE_INSERT || in_mode == MODE_FIND_ID ||
                       in_mode == MODE_FIND_VAL || in_mode == MODE_DELETE) begin
            state_nxt = S_SCAN;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end
      S_SCAN: begin
        // issue the next read
        if (issue_r != CNT_END) begin
          mem_re       = 1'b1;
          mem_raddr    = issue_r[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[AW-1:0];
          issue_nxt    = issue_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // examine the row read last cycle
        if (pend_r) begin
          case (mode_r)
            MODE_INSERT: begin
              if (!row_vld) begin
                mem_we         = 1'b1;
                mem_waddr      = pend_idx_r;
                mem_wdata      = {1'b1, cnt_inc, val_r};
                cnt_nxt        = cnt_inc;
                res_status_nxt = ST_OK;
                res_slot_nxt   = SLOT_W'(pend_idx_r);
                res_id_nxt     = cnt_inc;
                res_val_nxt    = val_r;
                pend_nxt       = 1'b0;
                state_nxt      = S_RESP;
              end
            end
            MODE_FIND_ID, MODE_FIND_VAL: begin
              if (row_vld && ((mode_r == MODE_FIND_ID) ? (row_id == key_r)
                                                       : (row_val == val_r))) begin
                res_status_nxt = ST_OK;
                res_slot_nxt   = SLOT_W'(pend_idx_r);
                res_id_nxt     = row_id;
                res_val_nxt    = row_val;
                pend_nxt       = 1'b0;
                state_nxt      = S_RESP;
              end
            end
            MODE_DELETE: begin
              if (row_vld && row_id == key_r) begin
                mem_we    = 1'b1;
                mem_waddr = pend_idx_r;
                mem_wdata = {1'b0, row_id, row_val};
              end
            end
            default: begin
            end
          endcase
        end else if (issue_r == CNT_END) begin
          // every row examined without a stop
          if (mode_r == MODE_INSERT) begin
            res_status_nxt = ST_FULL;
          end else if (mode_r == MODE_DELETE) begin
            res_status_nxt = ST_OK;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_id_nxt     = res_id_r;
          out_val_nxt    = res_val_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_id_r     <= res_id_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_id_r     <= out_id_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_entry_id    = out_id_r;
  assign out_entry_value = out_val_r;

  // a write during the scan must never land on the row being read
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("write and read hit the same row");

  // the id counter only ever advances by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == $past(cnt_r) + 32'd1))
    else $error("id counter jumped");

  // a waiting result is not dropped while the receiver stalls
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_ready) |=> (state_r == S_RESP))
    else $error("result left response state under stall");

  // the scan counter never runs past the table
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (issue_r <= CNT_END))
    else $error("scan counter out of range");

endmodule
